[hw/rtl/irpt_pkg.sv]
//------------------------------------------------------------------------------
// irpt_pkg
// Shared constants and types for the IR pointer two-point tracker.
//------------------------------------------------------------------------------
package irpt_pkg;

    localparam int SPOT_COUNT_DEF = 4;
    localparam int COORD_BITS_DEF = 12;
    localparam int SPOT_BITS      = 10;
    localparam int CFG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = 8;
    localparam int OUT_BITS       = 12;
    localparam int DIV_BITS       = 24;

    localparam logic [CFG_IDX_BITS-1:0] CFG_RADIUS = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAXS   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MINS   = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WEIGHT = 2'd3;

    localparam logic [7:0] RADIUS_RST = 8'd10;
    localparam logic [7:0] MAXS_RST   = 8'd8;
    localparam logic [7:0] MINS_RST   = 8'd4;
    localparam logic [3:0] WEIGHT_RST = 4'd3;

    localparam logic [SPOT_BITS-1:0] SPOT_MAX = 10'd1023;

    // Datapath micro-steps issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SPOT,
        OP_PAIR,
        OP_DIVX,
        OP_DIVY,
        OP_GATE,
        OP_WDIVX,
        OP_WDIVY,
        OP_WEND,
        OP_FINISH
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] spot;
        logic       div_start;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic weight_on;
    } t_sts;

endpackage

[hw/rtl/irpt_div.sv]
//------------------------------------------------------------------------------
// irpt_div
// Radix-2 signed divider, quotient truncated toward zero, one bit per cycle.
//------------------------------------------------------------------------------
module irpt_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [irpt_pkg::DIV_BITS-1:0] i_num,
    input  logic [8:0]                    i_den,
    output logic                          o_busy,
    output logic signed [irpt_pkg::DIV_BITS-1:0] o_quo
);
    import irpt_pkg::*;

    logic [DIV_BITS-1:0] r_q, n_q;
    logic [9:0]          r_rem, n_rem;
    logic [4:0]          r_cnt, n_cnt;
    logic                r_neg, n_neg;
    logic                r_busy, n_busy;
    logic [8:0]          r_den, n_den;
    logic [9:0]          w_sh;

    always_comb begin
        n_q = r_q; n_rem = r_rem; n_cnt = r_cnt; n_neg = r_neg;
        n_busy = r_busy; n_den = r_den;
        w_sh = {r_rem[8:0], r_q[DIV_BITS-1]};
        if (i_start) begin
            n_neg  = i_num[DIV_BITS-1];
            n_q    = i_num[DIV_BITS-1] ? -i_num : i_num;
            n_rem  = '0;
            n_den  = i_den;
            n_cnt  = 5'(DIV_BITS);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_q = {r_q[DIV_BITS-2:0], 1'b0};
            if (w_sh >= {1'b0, r_den}) begin
                n_rem  = w_sh - {1'b0, r_den};
                n_q[0] = 1'b1;
            end else begin
                n_rem = w_sh;
            end
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == 5'd1) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_q <= n_q; r_rem <= n_rem; r_neg <= n_neg; r_den <= n_den;
    end

    assign o_busy = r_busy;
    assign o_quo  = r_neg ? -$signed(r_q) : $signed(r_q);

    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt == 5'd1 && !i_start) |=> !r_busy)
        else $error("divider did not finish");
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy)
        else $error("divider did not start");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt != 5'd0)
        else $error("busy with zero count");
endmodule

[hw/rtl/irpt_datapath.sv]
//------------------------------------------------------------------------------
// irpt_datapath
// Spot pairing, running average and output shaping for the tracker.
//------------------------------------------------------------------------------
module irpt_datapath #(
    parameter int SPOT_COUNT = irpt_pkg::SPOT_COUNT_DEF,
    parameter int COORD_BITS = irpt_pkg::COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  irpt_pkg::t_cmd                i_cmd,
    output irpt_pkg::t_sts                o_sts,
    input  logic [irpt_pkg::SPOT_BITS*8-1:0] i_spots,
    input  logic                          i_cfg_we,
    input  logic [irpt_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [irpt_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    output logic [irpt_pkg::OUT_BITS-1:0] o_px,
    output logic [irpt_pkg::OUT_BITS-1:0] o_py
);
    import irpt_pkg::*;

    localparam int W = COORD_BITS + 4;
    localparam int D = 2 * W + 2;
    localparam logic signed [W-1:0] SMAX = W'((64'sd1 <<< (COORD_BITS - 1)) - 1);
    localparam logic signed [W-1:0] SMIN = -SMAX - W'(1);

    typedef logic signed [W-1:0] t_w;

    function automatic t_w satf(input t_w v);
        t_w res;
        res = v;
        if (v > SMAX) res = SMAX;
        if (v < SMIN) res = SMIN;
        return res;
    endfunction

    function automatic logic signed [D-1:0] dsq(input t_w ax, input t_w ay,
                                                input t_w bx, input t_w by);
        logic signed [W:0] dx, dy;
        dx = {ax[W-1], ax} - {bx[W-1], bx};
        dy = {ay[W-1], ay} - {by[W-1], by};
        return D'(dx * dx) + D'(dy * dy);
    endfunction

    logic [7:0] r_radius, r_maxs, r_mins;
    logic [3:0] r_weight;
    t_w r_ref_x, r_ref_y, r_vec_x, r_vec_y, r_avg_x, r_avg_y, r_prev_x, r_prev_y;
    logic [7:0] r_cnt;
    logic [SPOT_BITS*8-1:0] r_in;
    logic r_has_a, r_has_b;
    t_w r_ax, r_ay, r_bx, r_by, r_mx, r_my;
    logic [8:0] r_ncnt;
    logic [OUT_BITS-1:0] r_px, r_py;
    logic r_on;
    logic r_gate;

    logic div_start, div_busy;
    logic signed [DIV_BITS-1:0] div_num, div_quo;
    logic [8:0] div_den;

    t_w cx, cy, dxr, dyr, nbx, nby;
    logic signed [D-1:0] dc, da, db, t0, t1, t2;
    logic cvalid;
    t_w rxv, ryv, ox, oy, pxv;
    logic near;

    irpt_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(div_num), .i_den(div_den), .o_busy(div_busy), .o_quo(div_quo)
    );

    always_comb begin
        cx  = W'(r_in[i_cmd.spot*20 +: SPOT_BITS]);
        cy  = W'(r_in[i_cmd.spot*20 + 10 +: SPOT_BITS]);
        cvalid = !((cx == W'(SPOT_MAX) && cy == W'(SPOT_MAX)) || (cx == '0 && cy == '0));
        dxr = r_ref_x + r_vec_x;
        dyr = r_ref_y + r_vec_y;
        dc = dsq(cx, cy, r_ref_x, r_ref_y);
        da = dsq(r_ax, r_ay, r_ref_x, r_ref_y);
        db = dsq(r_bx, r_by, r_ref_x, r_ref_y);
        t0 = dsq(cx, cy, dxr, dyr);
        t1 = dsq(r_ax, r_ay, dxr, dyr);
        t2 = dsq(r_bx, r_by, dxr, dyr);
        if (t0 < dc) dc = t0;
        if (t1 < da) da = t1;
        if (t2 < db) db = t2;
        nbx = r_ax - r_vec_x;
        nby = r_ay - r_vec_y;
        near = dsq(r_mx, r_my, r_avg_x, r_avg_y) <
               D'({8'd0, r_radius} * {8'd0, r_radius});
        rxv = r_has_a ? satf(r_mx) : '0;
        ryv = r_has_a ? satf(r_my) : '0;
        ox  = (rxv == '0) ? r_prev_x : rxv;
        oy  = (ryv == '0) ? r_prev_y : ryv;
        pxv = ox - t_w'(SPOT_MAX);
        if (pxv < 0) pxv = -pxv;
        div_start = i_cmd.div_start;
        div_num = '0;
        div_den = {1'b0, r_cnt} + 9'd1;
        case (i_cmd.op)
            OP_DIVX:  div_num = DIV_BITS'(r_avg_x) * DIV_BITS'($signed({1'b0, r_cnt}))
                                + DIV_BITS'(r_mx);
            OP_DIVY:  div_num = DIV_BITS'(r_avg_y) * DIV_BITS'($signed({1'b0, r_cnt}))
                                + DIV_BITS'(r_my);
            OP_WDIVX: begin
                div_num = DIV_BITS'(r_mx) + DIV_BITS'(r_avg_x)
                          * DIV_BITS'($signed({1'b0, r_weight}));
                div_den = {5'd0, r_weight} + 9'd1;
            end
            OP_WDIVY: begin
                div_num = DIV_BITS'(r_my) + DIV_BITS'(r_avg_y)
                          * DIV_BITS'($signed({1'b0, r_weight}));
                div_den = {5'd0, r_weight} + 9'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RST; r_maxs <= MAXS_RST;
            r_mins <= MINS_RST; r_weight <= WEIGHT_RST;
            r_ref_x <= '0; r_ref_y <= '0; r_vec_x <= '0; r_vec_y <= '0;
            r_avg_x <= '0; r_avg_y <= '0; r_prev_x <= '0; r_prev_y <= '0;
            r_cnt <= '0; r_has_a <= 1'b0; r_has_b <= 1'b0;
            r_on <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RADIUS: r_radius <= i_cfg_data;
                    CFG_MAXS:   r_maxs <= i_cfg_data;
                    CFG_MINS:   r_mins <= i_cfg_data;
                    CFG_WEIGHT: r_weight <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            case (i_cmd.op)
                OP_LOAD: begin
                    r_in <= i_spots; r_has_a <= 1'b0; r_has_b <= 1'b0;
                    r_on <= 1'b0;
                end
                OP_SPOT: if (cvalid && int'(i_cmd.spot) < SPOT_COUNT) begin
                    if (!r_has_a) begin
                        r_ax <= cx; r_ay <= cy; r_has_a <= 1'b1;
                    end else if (!r_has_b) begin
                        r_bx <= cx; r_by <= cy; r_has_b <= 1'b1;
                    end else if (dc < da) begin
                        if (db < da) begin
                            r_ax <= cx; r_ay <= cy;
                        end else begin
                            r_bx <= cx; r_by <= cy;
                        end
                    end else if (dc < db) begin
                        r_bx <= cx; r_by <= cy;
                    end
                end
                OP_PAIR: if (r_has_a) begin
                    if (!r_has_b) begin
                        if (dsq(r_ax, r_ay, r_ref_x, r_ref_y) <
                            dsq(nbx, nby, r_ref_x, r_ref_y)) begin
                            r_bx <= r_ax + r_vec_x; r_by <= r_ay + r_vec_y;
                            r_mx <= (r_ax + r_ax + r_vec_x) / 2;
                            r_my <= (r_ay + r_ay + r_vec_y) / 2;
                            r_ref_x <= satf(r_ax); r_ref_y <= satf(r_ay);
                        end else begin
                            r_bx <= nbx; r_by <= nby;
                            r_mx <= (r_ax + nbx) / 2; r_my <= (r_ay + nby) / 2;
                            r_ref_x <= satf(nbx); r_ref_y <= satf(nby);
                        end
                    end else begin
                        r_vec_x <= satf(r_bx - r_ax); r_vec_y <= satf(r_by - r_ay);
                        r_ref_x <= satf(r_ax); r_ref_y <= satf(r_ay);
                        r_mx <= (r_ax + r_bx) / 2; r_my <= (r_ay + r_by) / 2;
                    end
                    r_ncnt <= ({1'b0, r_cnt} + 9'd1 > {1'b0, r_maxs}) ?
                              {1'b0, r_maxs} : {1'b0, r_cnt} + 9'd1;
                end
                OP_DIVY: if (r_has_a) r_avg_x <= satf(W'(div_quo));
                OP_GATE: if (r_has_a) r_avg_y <= satf(W'(div_quo));
                OP_WDIVY: r_mx <= W'(div_quo);
                OP_WEND: r_my <= W'(div_quo);
                OP_FINISH: begin
                    r_prev_x <= rxv; r_prev_y <= ryv;
                end
                default: ;
            endcase
            if (r_gate && r_has_a) begin
                r_on <= near && (r_ncnt >= {1'b0, r_mins});
                r_cnt <= near ? r_ncnt[7:0] : 8'd0;
            end
        end
        if (i_cmd.op == OP_FINISH) begin
            r_px <= OUT_BITS'(pxv);
            r_py <= OUT_BITS'(oy);
        end
    end

    // Gate and count update are driven by r_gate, which registers the OP_GATE step in which the y average lands.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_gate <= 1'b0;
        else r_gate <= (i_cmd.op == OP_GATE);
    end

    assign o_sts.div_busy  = div_busy;
    assign o_sts.weight_on = r_on;
    assign o_px = r_px;
    assign o_py = r_py;

    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_has_b |-> r_has_a) else $error("second spot without first");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_gate && r_has_a) |=> r_cnt <= r_maxs) else $error("count above cap");
    a_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy) else $error("divider restarted while busy");
endmodule

[hw/rtl/irpt_ctrl.sv]
//------------------------------------------------------------------------------
// irpt_ctrl
// Sequencer for one report: spot scan, pairing, average and weighting steps.
//------------------------------------------------------------------------------
module irpt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output irpt_pkg::t_cmd o_cmd,
    input  irpt_pkg::t_sts i_sts
);
    import irpt_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0, S_SPOT = 4'd1, S_PAIR = 4'd2,
                           S_DX = 4'd3, S_DY = 4'd4, S_GATE = 4'd5,
                           S_CHK = 4'd6, S_WX = 4'd7, S_WY = 4'd8,
                           S_WEND = 4'd9, S_FIN = 4'd10, S_DXW = 4'd11,
                           S_WXW = 4'd12;

    logic [3:0] r_state, n_state;
    logic [1:0] r_spot, n_spot;
    logic       r_ov, n_ov, r_go;
    logic       accept;

    assign accept = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE) || r_ov;

    always_comb begin
        n_state = r_state; n_spot = r_spot; n_ov = r_ov;
        o_cmd = '{op: OP_NONE, spot: r_spot, div_start: 1'b0};
        if (r_ov && !i_out_stall) n_ov = 1'b0;
        case (r_state)
            S_IDLE: if (accept) begin
                o_cmd.op = OP_LOAD; n_spot = '0; n_state = S_SPOT;
            end
            S_SPOT: begin
                o_cmd.op = OP_SPOT;
                n_spot = r_spot + 2'd1;
                if (r_spot == 2'd3) n_state = S_PAIR;
            end
            S_PAIR: begin o_cmd.op = OP_PAIR; n_state = S_DX; end
            S_DX: begin o_cmd.op = OP_DIVX; o_cmd.div_start = 1'b1; n_state = S_DXW; end
            S_DXW: if (!i_sts.div_busy) begin
                o_cmd.op = OP_DIVY; o_cmd.div_start = 1'b1; n_state = S_DY;
            end
            S_DY: if (!i_sts.div_busy) begin o_cmd.op = OP_GATE; n_state = S_GATE; end
            S_GATE: n_state = S_CHK;
            S_CHK: n_state = i_sts.weight_on ? S_WX : S_FIN;
            S_WX: begin o_cmd.op = OP_WDIVX; o_cmd.div_start = 1'b1; n_state = S_WXW; end
            S_WXW: if (!i_sts.div_busy) begin
                o_cmd.op = OP_WDIVY; o_cmd.div_start = 1'b1; n_state = S_WY;
            end
            S_WY: if (!i_sts.div_busy) begin o_cmd.op = OP_WEND; n_state = S_WEND; end
            S_WEND: n_state = S_FIN;
            S_FIN: if (!r_ov) begin
                o_cmd.op = OP_FINISH; n_ov = 1'b1; n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_spot <= '0; r_ov <= 1'b0; r_go <= 1'b0;
        end else begin
            r_state <= n_state; r_spot <= n_spot; r_ov <= n_ov; r_go <= accept;
        end
    end

    assign o_out_valid = r_ov;

    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_go |-> r_state == S_SPOT) else $error("accept did not start scan");
    a_ov: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && i_out_stall) |=> r_ov) else $error("result dropped");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> o_in_stall) else $error("accepted while busy");
endmodule

[hw/rtl/ir_pointer_two_point_tracker.sv]
//------------------------------------------------------------------------------
// ir_pointer_two_point_tracker
// Turns one four-spot IR camera report into one pointer position.
//------------------------------------------------------------------------------
// The result of a transaction is valid in the output register once the steps
// are through: a scan of the four spots, a pairing step, then two or four
// passes through one shared bit-serial divider, four when the weighted blend
// applies. A finished result sits in an output register, and the next report
// is taken the cycle after it is gone, so a new report is never taken while
// one is in work or its result still waits.
//------------------------------------------------------------------------------
module ir_pointer_two_point_tracker #(
    parameter int SPOT_COUNT = irpt_pkg::SPOT_COUNT_DEF,
    parameter int COORD_BITS = irpt_pkg::COORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [9:0]  i_spot0_x,
    input  logic [9:0]  i_spot0_y,
    input  logic [9:0]  i_spot1_x,
    input  logic [9:0]  i_spot1_y,
    input  logic [9:0]  i_spot2_x,
    input  logic [9:0]  i_spot2_y,
    input  logic [9:0]  i_spot3_x,
    input  logic [9:0]  i_spot3_y,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [11:0] o_pointer_x,
    output logic signed [11:0] o_pointer_y
);
    import irpt_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic [11:0] py;

    irpt_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_valid), .o_in_stall(o_stall),
        .o_out_valid(o_valid), .i_out_stall(i_stall), .o_cmd(cmd), .i_sts(sts)
    );

    irpt_datapath #(.SPOT_COUNT(SPOT_COUNT), .COORD_BITS(COORD_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_sts(sts),
        .i_spots({i_spot3_y, i_spot3_x, i_spot2_y, i_spot2_x,
                  i_spot1_y, i_spot1_x, i_spot0_y, i_spot0_x}),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_px(o_pointer_x), .o_py(py)
    );

    assign o_pointer_y = $signed(py);
endmodule
